>>> rtl/core/ssp_pkg.sv
// ============================================================================
// ssp_pkg: shared constants and types for the shortest path block
// Field widths, register map, operation codes and the result word layout
// shared by the top level and the search engine.
// ============================================================================
package ssp_pkg;

    localparam int VERTICES_DEFAULT    = 32;
    localparam int WEIGHT_BITS_DEFAULT = 16;

    // Fixed widths of the interface fields.
    localparam int VTX_FIELD_BITS    = 5;
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int DIST_BITS         = 22;

    // All ones means unreached; path sums saturate here.
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // A run never reports more than this many settled vertices.
    localparam int MAX_RESULTS = 32;

    // Configuration port.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_UNDIRECTED = '0;

    // Operation codes carried in the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RUN   = 1'b1;

    typedef struct packed {
        logic [VTX_FIELD_BITS-1:0] settled_vertex;
        logic [VTX_FIELD_BITS-1:0] predecessor;
        logic [DIST_BITS-1:0]      distance;
        logic [VTX_FIELD_BITS-1:0] run_source;
        logic                      last;
    } ssp_result_t;

endpackage

>>> rtl/core/ssp_engine.sv
// ============================================================================
// ssp_engine: array-based Dijkstra search sequencer
// Holds the tentative distance and predecessor memories and the settled
// flags, and walks init, scan and relax passes over the vertex list.
// ============================================================================
module ssp_engine #(
    parameter int VERTICES    = ssp_pkg::VERTICES_DEFAULT,
    parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [$clog2(VERTICES)-1:0]            start_src,
    output logic                                   busy,
    output logic [$clog2(VERTICES*VERTICES)-1:0]   w_raddr,
    input  logic [WEIGHT_BITS-1:0]                 w_rdata,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output ssp_pkg::ssp_result_t                   res_word
);
    import ssp_pkg::*;

    localparam int VB    = $clog2(VERTICES);
    localparam int AW    = $clog2(VERTICES * VERTICES);
    localparam int IW    = $clog2(VERTICES + 1);
    localparam int LIMIT = (VERTICES < MAX_RESULTS) ? VERTICES : MAX_RESULTS;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int SW    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

    typedef enum logic [2:0] {
        E_IDLE,
        E_INIT,
        E_SCAN,
        E_EMIT,
        E_RELAX
    } eng_state_t;

    eng_state_t            state_reg;
    logic [IW-1:0]         idx_reg;
    logic                  pv_reg;
    logic [VB-1:0]         pj_reg;
    logic [VB-1:0]         src_reg;
    logic [VB-1:0]         u_reg;
    logic [DIST_BITS-1:0]  du_reg;
    logic [DIST_BITS-1:0]  best_d_reg;
    logic [VB-1:0]         best_v_reg;
    logic [VB-1:0]         best_p_reg;
    logic                  found_reg;
    logic                  final_reg;
    logic [VB-1:0]         pend_v_reg;
    logic [VB-1:0]         pend_p_reg;
    logic [DIST_BITS-1:0]  pend_d_reg;
    logic [CW-1:0]         cnt_reg;
    logic [VERTICES-1:0]   settled_reg;
    ssp_result_t           out_reg;
    logic                  out_valid_reg;

    logic [DIST_BITS-1:0]  dist_mem [VERTICES];
    logic [VB-1:0]         pred_mem [VERTICES];
    logic [DIST_BITS-1:0]  dist_q;
    logic [VB-1:0]         pred_q;

    logic                  issue;
    logic [VB-1:0]         rd_addr;
    logic [VB-1:0]         row;
    logic                  phase_end;
    logic                  e_none;
    logic [SW-1:0]         e_ext;
    logic [SW-1:0]         sum;
    logic [DIST_BITS-1:0]  e_clamped;
    logic [DIST_BITS-1:0]  nd;
    logic                  j_settled;
    logic                  relax_upd;
    logic                  cand;
    logic                  mem_we;
    logic [DIST_BITS-1:0]  mem_wd_dist;
    logic [VB-1:0]         mem_wd_pred;
    logic                  slot_free;

    always_comb begin
        issue = ((state_reg == E_INIT) || (state_reg == E_SCAN) || (state_reg == E_RELAX))
                && (idx_reg < IW'(VERTICES));
        rd_addr   = idx_reg[VB-1:0];
        row       = (state_reg == E_INIT) ? src_reg : u_reg;
        w_raddr   = AW'(row) * AW'(VERTICES) + AW'(rd_addr);
        phase_end = (idx_reg == IW'(VERTICES));

        e_none    = (w_rdata == NO_EDGE);
        e_ext     = SW'(w_rdata);
        e_clamped = (e_none || (e_ext >= SW'(DIST_MAX))) ? DIST_MAX : DIST_BITS'(w_rdata);
        sum       = SW'(du_reg) + e_ext;
        nd        = (sum >= SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);

        j_settled = settled_reg[pj_reg];
        relax_upd = pv_reg && !j_settled && !e_none && (nd < dist_q);
        cand      = pv_reg && !j_settled && (dist_q < best_d_reg);

        mem_we      = 1'b0;
        mem_wd_dist = nd;
        mem_wd_pred = u_reg;
        case (state_reg)
            E_INIT: begin
                mem_we      = pv_reg;
                mem_wd_dist = (pj_reg == src_reg) ? '0 : e_clamped;
                mem_wd_pred = src_reg;
            end
            E_RELAX: begin
                mem_we = relax_upd;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase

        slot_free = !out_valid_reg || res_ready;
    end

    // Distance and predecessor memories: one write, one registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dist_mem[pj_reg] <= mem_wd_dist;
            pred_mem[pj_reg] <= mem_wd_pred;
        end
        dist_q <= dist_mem[rd_addr];
        pred_q <= pred_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_IDLE;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            settled_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pv_reg <= issue;
            pj_reg <= rd_addr;
            if (issue) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (out_valid_reg && res_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        src_reg     <= start_src;
                        settled_reg <= VERTICES'(1) << start_src;
                        idx_reg     <= '0;
                        state_reg   <= E_INIT;
                    end
                end
                E_INIT: begin
                    if (phase_end) begin
                        pend_v_reg <= src_reg;
                        pend_p_reg <= src_reg;
                        pend_d_reg <= '0;
                        cnt_reg    <= CW'(1);
                        best_d_reg <= DIST_MAX;
                        found_reg  <= 1'b0;
                        idx_reg    <= '0;
                        state_reg  <= E_SCAN;
                    end
                end
                E_SCAN: begin
                    if (cand) begin
                        best_d_reg <= dist_q;
                        best_v_reg <= pj_reg;
                        best_p_reg <= pred_q;
                        found_reg  <= 1'b1;
                    end
                    if (phase_end) begin
                        final_reg <= !(found_reg || cand);
                        state_reg <= E_EMIT;
                    end
                end
                E_EMIT: begin
                    if (slot_free) begin
                        out_reg.settled_vertex <= VTX_FIELD_BITS'(pend_v_reg);
                        out_reg.predecessor    <= VTX_FIELD_BITS'(pend_p_reg);
                        out_reg.distance       <= pend_d_reg;
                        out_reg.run_source     <= VTX_FIELD_BITS'(src_reg);
                        out_reg.last           <= final_reg;
                        out_valid_reg          <= 1'b1;
                        if (final_reg) begin
                            state_reg <= E_IDLE;
                        end else begin
                            pend_v_reg              <= best_v_reg;
                            pend_p_reg              <= best_p_reg;
                            pend_d_reg              <= best_d_reg;
                            cnt_reg                 <= cnt_reg + CW'(1);
                            settled_reg[best_v_reg] <= 1'b1;
                            u_reg                   <= best_v_reg;
                            du_reg                  <= best_d_reg;
                            idx_reg                 <= '0;
                            state_reg               <= E_RELAX;
                        end
                    end
                end
                E_RELAX: begin
                    if (phase_end) begin
                        if (cnt_reg >= CW'(LIMIT)) begin
                            final_reg <= 1'b1;
                            state_reg <= E_EMIT;
                        end else begin
                            best_d_reg <= DIST_MAX;
                            found_reg  <= 1'b0;
                            idx_reg    <= '0;
                            state_reg  <= E_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != E_IDLE);
    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

endmodule

>>> rtl/core/single_source_shortest_path.sv
// ============================================================================
// single_source_shortest_path: dense-matrix Dijkstra search block
// Stores a weighted adjacency matrix and runs single-source shortest path
// searches over it, reporting each settled vertex as a result word.
// ============================================================================
//
//  Channel  Ports                        Direction  Carries
//  -------  ---------------------------  ---------  -------------------------------
//  config   psel/penable/pwrite/paddr..  in/out     undirected mode register
//  input    s_valid/s_ready/s_*          in         edge write or search request
//  result   m_valid/m_ready/m_*          out        settled vertex, path, distance
//
// After reset the weight matrix is cleared one entry per cycle, VERTICES
// squared entries in all (1024 at the default size); s_ready stays low until
// this pass is done. Configuration writes are taken throughout.
// An undirected edge write also writes the mirrored entry in a second step,
// as the matrix memory has a single write port. A search loads the source
// row, then for each settled vertex makes one scan pass and one relax pass
// over the vertex list and hands over the word; the pace of a full run is
// set by the single read port of each memory. A result word waiting on
// m_ready holds the search back only when the next word is ready to leave.
//
module single_source_shortest_path #(
    parameter int VERTICES    = ssp_pkg::VERTICES_DEFAULT,
    parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ssp_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [ssp_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [ssp_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    // Input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [ssp_pkg::VTX_FIELD_BITS-1:0]   s_from_vertex,
    input  logic [ssp_pkg::VTX_FIELD_BITS-1:0]   s_to_vertex,
    input  logic [ssp_pkg::WEIGHT_FIELD_BITS-1:0] s_edge_weight,
    input  logic [ssp_pkg::VTX_FIELD_BITS-1:0]   s_source_vertex,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ssp_pkg::VTX_FIELD_BITS-1:0]   m_settled_vertex,
    output logic [ssp_pkg::VTX_FIELD_BITS-1:0]   m_predecessor,
    output logic [ssp_pkg::DIST_BITS-1:0]        m_distance,
    output logic [ssp_pkg::VTX_FIELD_BITS-1:0]   m_run_source,
    output logic                                 m_last
);
    import ssp_pkg::*;

    localparam int VB = $clog2(VERTICES);
    localparam int AW = $clog2(VERTICES * VERTICES);

    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_MIRROR
    } top_state_t;

    // The matrix is laid out row by row: entry (r, c) sits at r*VERTICES+c.
    function automatic logic [AW-1:0] cell_addr(input logic [VB-1:0] r,
                                                input logic [VB-1:0] c);
        return AW'(r) * AW'(VERTICES) + AW'(c);
    endfunction

    top_state_t              state_reg;
    logic [VB-1:0]           clr_row_reg;
    logic [VB-1:0]           clr_col_reg;
    logic [VB-1:0]           mir_row_reg;
    logic [VB-1:0]           mir_col_reg;
    logic [WEIGHT_BITS-1:0]  mir_w_reg;
    logic                    undirected_reg;

    logic [WEIGHT_BITS-1:0]  wmem [VERTICES*VERTICES];
    logic [WEIGHT_BITS-1:0]  w_rdata_reg;

    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    apb_write;
    logic                    s_accept;
    logic [VB-1:0]           in_from;
    logic [VB-1:0]           in_to;
    logic [VB-1:0]           in_src;
    logic [WEIGHT_BITS-1:0]  in_weight;
    logic                    from_ok;
    logic                    to_ok;
    logic                    src_ok;
    logic                    edge_write;
    logic                    clr_last_col;
    logic                    clr_done;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [WEIGHT_BITS-1:0]  mem_wdata;
    logic                    eng_start;
    logic                    eng_busy;
    logic [AW-1:0]           eng_raddr;
    ssp_result_t             eng_word;

    // ------------------------------------------------------------------
    // Configuration register. The register index is the word address;
    // the byte offset bits are not decoded.
    // ------------------------------------------------------------------
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign apb_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_UNDIRECTED) ? APB_DATA_BITS'(undirected_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            undirected_reg <= 1'b1;
        end else if (apb_write && (reg_idx == REG_UNDIRECTED)) begin
            undirected_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Input decode. Vertex numbers outside the matrix make a write or a
    // search do nothing; the weight is cut to the stored width, which for
    // narrow weights also folds large values onto the no-edge code.
    // ------------------------------------------------------------------
    assign s_ready    = (state_reg == T_IDLE) && !eng_busy;
    assign s_accept   = s_valid && s_ready;
    assign in_from    = VB'(s_from_vertex);
    assign in_to      = VB'(s_to_vertex);
    assign in_src     = VB'(s_source_vertex);
    assign in_weight  = WEIGHT_BITS'(s_edge_weight);
    assign from_ok    = int'(s_from_vertex) < VERTICES;
    assign to_ok      = int'(s_to_vertex) < VERTICES;
    assign src_ok     = int'(s_source_vertex) < VERTICES;
    assign edge_write = s_accept && (s_func == FUNC_WRITE) && from_ok && to_ok;
    assign eng_start  = s_accept && (s_func == FUNC_RUN) && src_ok;

    assign clr_last_col = (clr_col_reg == VB'(VERTICES - 1));
    assign clr_done     = clr_last_col && (clr_row_reg == VB'(VERTICES - 1));

    // ------------------------------------------------------------------
    // Write port of the weight matrix: the clearing pass after reset,
    // an edge write, and the mirrored entry of an undirected write.
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr(in_from, in_to);
        mem_wdata = in_weight;
        case (state_reg)
            T_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(clr_row_reg, clr_col_reg);
                mem_wdata = (clr_row_reg == clr_col_reg) ? '0 : NO_EDGE;
            end
            T_IDLE: begin
                mem_we = edge_write;
            end
            T_MIRROR: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(mir_row_reg, mir_col_reg);
                mem_wdata = mir_w_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Writes only happen while the engine is idle, so the engine's reads
    // never meet a write to the same entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wmem[mem_waddr] <= mem_wdata;
        end
        w_rdata_reg <= wmem[eng_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_CLEAR;
            clr_row_reg <= '0;
            clr_col_reg <= '0;
        end else begin
            case (state_reg)
                T_CLEAR: begin
                    if (clr_done) begin
                        state_reg <= T_IDLE;
                    end else if (clr_last_col) begin
                        clr_col_reg <= '0;
                        clr_row_reg <= clr_row_reg + VB'(1);
                    end else begin
                        clr_col_reg <= clr_col_reg + VB'(1);
                    end
                end
                T_IDLE: begin
                    if (edge_write && undirected_reg) begin
                        mir_row_reg <= in_to;
                        mir_col_reg <= in_from;
                        mir_w_reg   <= in_weight;
                        state_reg   <= T_MIRROR;
                    end
                end
                T_MIRROR: begin
                    state_reg <= T_IDLE;
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Search engine and result word unpacking.
    // ------------------------------------------------------------------
    ssp_engine #(
        .VERTICES    (VERTICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .start_src (in_src),
        .busy      (eng_busy),
        .w_raddr   (eng_raddr),
        .w_rdata   (w_rdata_reg),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_word  (eng_word)
    );

    assign m_settled_vertex = eng_word.settled_vertex;
    assign m_predecessor    = eng_word.predecessor;
    assign m_distance       = eng_word.distance;
    assign m_run_source     = eng_word.run_source;
    assign m_last           = eng_word.last;

`ifndef SYNTHESIS
    // The matrix is never written while a search is reading it.
    a_no_write_during_run: assert property (
        @(posedge aclk) disable iff (!aresetn)
        mem_we |-> !eng_busy
    ) else $error("weight matrix written while a search is running");

    // Once a search starts, no further input word is taken until it ends.
    a_run_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        eng_start |=> !s_ready
    ) else $error("input accepted in the cycle after a search started");

    // An undirected edge write is always followed by its mirrored entry.
    a_mirror_follows: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (edge_write && undirected_reg) |=> (state_reg == T_MIRROR) && mem_we
    ) else $error("mirrored edge entry not written after undirected write");
`endif

endmodule

>>> tb/sv/single_source_shortest_path_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_source_shortest_path_tb: self-checking bench for the Dijkstra block
// Loads edge weights and starts searches through the input channel. A
// behavioural copy of the matrix predicts every settled-vertex word, and each
// word that leaves the block is checked against that prediction in order.
// ----------------------------------------------------------------------------
module single_source_shortest_path_tb;
    import ssp_pkg::*;

    localparam int NV             = VERTICES_DEFAULT;
    localparam int VTX_W          = VTX_FIELD_BITS;
    localparam int WT_W           = WEIGHT_FIELD_BITS;
    localparam logic [WT_W-1:0] NO_EDGE = '1;

    // Register map: register i sits at byte address 4*i. Index 1 is unmapped
    // and a write there must leave the mode register alone.
    localparam logic [APB_ADDR_BITS-1:0] MODE_ADDR     = {REG_UNDIRECTED, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = {REG_UNDIRECTED + 1'b1, 2'b00};

    localparam int RANDOM_PER_PHASE = 90;
    localparam int RX_HOLD_CYCLES   = 5000;
    localparam int SETTLE_CYCLES    = 64;
    // Even if every word were a search reaching all vertices under the
    // heaviest stalls, this limit is ample.
    localparam int RUN_LIMIT        = 2_000_000;

    typedef struct packed {
        logic             func;
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        logic [WT_W-1:0]  weight;
        logic [VTX_W-1:0] src;
    } request_t;

    // ------------------------------------------------------------------
    // Block signals, the inputs all at known values from time zero.
    // ------------------------------------------------------------------
    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_DATA_BITS-1:0]  pwdata        = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_func        = FUNC_WRITE;
    logic [VTX_W-1:0]          s_from_vertex = '0;
    logic [VTX_W-1:0]          s_to_vertex   = '0;
    logic [WT_W-1:0]           s_edge_weight = '0;
    logic [VTX_W-1:0]          s_source_vertex = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [VTX_W-1:0]          m_settled_vertex;
    logic [VTX_W-1:0]          m_predecessor;
    logic [DIST_BITS-1:0]      m_distance;
    logic [VTX_W-1:0]          m_run_source;
    logic                      m_last;

    // ------------------------------------------------------------------
    // Bench state: the mirror of the weight matrix and mode register, the
    // words still waiting to be issued, and the settled-vertex words that
    // the block still owes us.
    // ------------------------------------------------------------------
    logic [WT_W-1:0] edge_w [NV][NV];
    logic            undirected = 1'b1;
    request_t        pending_q[$];
    ssp_result_t     settled_due_q[$];

    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 54;
    logic        hold_arm      = 1'b0;
    logic        hold_on       = 1'b0;

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned edges_taken   = 0;
    int unsigned searches_taken = 0;
    int unsigned words_checked = 0;
    int unsigned full_searches = 0;

    single_source_shortest_path DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_from_vertex    (s_from_vertex),
        .s_to_vertex      (s_to_vertex),
        .s_edge_weight    (s_edge_weight),
        .s_source_vertex  (s_source_vertex),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_settled_vertex (m_settled_vertex),
        .m_predecessor    (m_predecessor),
        .m_distance       (m_distance),
        .m_run_source     (m_run_source),
        .m_last           (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor. An edge word updates the mirror matrix, twice over in
    // undirected mode. A search word runs the array form of Dijkstra and
    // queues one word per settled vertex, the source first.
    // ------------------------------------------------------------------
    function automatic void store_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                       input logic [WT_W-1:0] w);
        edge_w[a][b] = w;
        if (undirected)
            edge_w[b][a] = w;
    endfunction

    function automatic void solve_paths(input logic [VTX_W-1:0] src);
        logic [DIST_BITS-1:0] tdist [NV];
        logic [VTX_W-1:0]     via [NV];
        bit                   settled [NV];
        ssp_result_t          words [MAX_RESULTS];
        ssp_result_t          w;
        logic [DIST_BITS-1:0] best;
        logic [DIST_BITS-1:0] nd;
        logic [DIST_BITS:0]   sum;
        int                   n;
        int                   u;
        bit                   found;

        // The source row gives the first relaxation for free.
        for (int i = 0; i < NV; i++) begin
            if (edge_w[src][i] == NO_EDGE)
                tdist[i] = DIST_MAX;
            else
                tdist[i] = DIST_BITS'(edge_w[src][i]);
            via[i] = src;
            settled[i] = 1'b0;
        end
        // The source is reported at distance zero whatever its diagonal says.
        settled[src] = 1'b1;
        tdist[src] = '0;
        words[0] = '{settled_vertex: src, predecessor: src, distance: '0,
                     run_source: src, last: 1'b0};
        n = 1;

        for (int step = 0; step < NV - 1 && n < MAX_RESULTS; step++) begin
            // Strictly smaller wins, so equal distances go to the lowest vertex,
            // and anything still at the saturated value is treated as unreached.
            best = DIST_MAX;
            found = 1'b0;
            u = 0;
            for (int j = 0; j < NV; j++) begin
                if (!settled[j] && tdist[j] < best) begin
                    best = tdist[j];
                    u = j;
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            settled[u] = 1'b1;
            for (int j = 0; j < NV; j++) begin
                if (!settled[j] && edge_w[u][j] != NO_EDGE) begin
                    sum = {1'b0, tdist[u]} + (DIST_BITS+1)'(edge_w[u][j]);
                    nd = (sum >= DIST_MAX) ? DIST_MAX : sum[DIST_BITS-1:0];
                    if (nd < tdist[j]) begin
                        tdist[j] = nd;
                        via[j] = VTX_W'(u);
                    end
                end
            end
            words[n] = '{settled_vertex: VTX_W'(u), predecessor: via[u], distance: tdist[u],
                         run_source: src, last: 1'b0};
            n++;
        end

        if (n == NV)
            full_searches++;
        for (int k = 0; k < n; k++) begin
            w = words[k];
            w.last = (k == n - 1);
            settled_due_q = {settled_due_q, w};
        end
    endfunction

    function automatic void report_word(input string why, input ssp_result_t want,
                                        input ssp_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%s: expected v%0d via %0d dist %0d src %0d last %0b, ",
                      "got v%0d via %0d dist %0d src %0d last %0b"},
                     why, want.settled_vertex, want.predecessor, want.distance,
                     want.run_source, want.last, got.settled_vertex, got.predecessor,
                     got.distance, got.run_source, got.last);
    endfunction

    // ------------------------------------------------------------------
    // Driver. A word is taken at an edge where valid and ready are both
    // high; the predictor sees it at that same edge, so expectations stay
    // in the order the block accepted them. A new word is only offered
    // once the previous one has gone, and valid is assigned once per edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed_words
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_func == FUNC_RUN) begin
                    searches_taken++;
                    solve_paths(s_source_vertex);
                end else begin
                    edges_taken++;
                    store_edge(s_from_vertex, s_to_vertex, s_edge_weight);
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_valid         <= 1'b1;
                    s_func          <= nxt.func;
                    s_from_vertex   <= nxt.from_v;
                    s_to_vertex     <= nxt.to_v;
                    s_edge_weight   <= nxt.weight;
                    s_source_vertex <= nxt.src;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every word that leaves is matched against the oldest
    // prediction; ready is dropped at random, and held low throughout
    // the long back-pressure window.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_words
        ssp_result_t got;
        ssp_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.settled_vertex = m_settled_vertex;
                got.predecessor    = m_predecessor;
                got.distance       = m_distance;
                got.run_source     = m_run_source;
                got.last           = m_last;
                words_checked++;
                if (settled_due_q.size() == 0) begin
                    report_word("Unexpected word", '0, got);
                end else begin
                    want = settled_due_q.pop_front();
                    if (got !== want)
                        report_word("Word mismatch", want, got);
                end
            end
            m_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering
    // words meanwhile; the block should fill up and drop s_ready.
    initial begin
        wait (hold_arm);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words still owed",
                     cycle_count, settled_due_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                              input logic [WT_W-1:0] w);
        request_t r;
        r.func   = FUNC_WRITE;
        r.from_v = a;
        r.to_v   = b;
        r.weight = w;
        r.src    = VTX_W'($urandom_range(NV - 1));
        pending_q = {pending_q, r};
    endtask

    task automatic queue_search(input logic [VTX_W-1:0] s);
        request_t r;
        r.func   = FUNC_RUN;
        r.from_v = VTX_W'($urandom_range(NV - 1));
        r.to_v   = VTX_W'($urandom_range(NV - 1));
        r.weight = WT_W'($urandom_range(2**WT_W - 1));
        r.src    = s;
        pending_q = {pending_q, r};
    endtask

    // Mostly small weights so that ties turn up often, with the extremes,
    // near-maximum weights and edge removals mixed in.
    function automatic logic [WT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return NO_EDGE;
            1:       return '0;
            2:       return WT_W'($urandom_range(2**WT_W - 2, 2**WT_W - 4096));
            3:       return WT_W'($urandom_range(2**WT_W - 1));
            default: return WT_W'($urandom_range(40, 1));
        endcase
    endfunction

    // Batches of edge words followed by a search or two. The matrix is never
    // cleared, so later batches search an ever denser graph.
    task automatic queue_random_items(input int count);
        int added;
        int nw;
        added = 0;
        while (added < count) begin
            nw = $urandom_range(12, 3);
            repeat (nw) queue_edge(VTX_W'($urandom_range(NV - 1)),
                                   VTX_W'($urandom_range(NV - 1)), pick_weight());
            repeat ($urandom_range(2, 1)) begin
                queue_search(VTX_W'($urandom_range(NV - 1)));
                added++;
            end
            added += nw;
        end
    endtask

    // Waits until every word has been accepted and every prediction met,
    // then lets the block finish any trailing edge write.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || settled_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // The register takes the write on the edge that closes the access phase.
    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == MODE_ADDR)
            undirected = data[0];
    endtask

    task automatic check_mode_reg();
        logic [APB_DATA_BITS-1:0] seen;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== {{(APB_DATA_BITS-1){1'b0}}, undirected}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mode register read %0h, expected %0b", seen, undirected);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        // The matrix comes out of reset with a zero diagonal and no edges.
        for (int i = 0; i < NV; i++)
            for (int j = 0; j < NV; j++)
                edge_w[i][j] = (i == j) ? '0 : NO_EDGE;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // A write to the unmapped index must not disturb the mode bit,
        // which still holds its reset value of undirected.
        apb_write(UNMAPPED_ADDR, '1);
        check_mode_reg();

        // Undirected mode. A search from a lone vertex gives a single word.
        queue_search(0);
        queue_edge(0, 1, '0);
        queue_edge(1, 2, NO_EDGE - 1'b1);
        queue_edge(0, 3, 10);
        queue_edge(3, 2, 10);
        queue_edge(0, 4, 20);
        queue_edge(NV - 1, NV - 2, NO_EDGE - 1'b1);
        queue_edge(0, NV - 1, NO_EDGE);
        // Vertices 2 and 4 tie at distance 20; the lower one must settle first.
        queue_search(0);
        queue_search(NV - 1);
        queue_search(2);
        wait_quiet();

        // Directed mode, set with the upper data bits high to show that
        // only bit 0 counts.
        apb_write(MODE_ADDR, {{(APB_DATA_BITS-1){1'b1}}, 1'b0});
        check_mode_reg();
        // A non-zero diagonal on the source must still report distance zero.
        queue_edge(7, 7, 100);
        queue_edge(7, 8, 1);
        queue_edge(8, 9, NO_EDGE - 1'b1);
        queue_edge(9, 7, 3);
        queue_search(7);
        queue_search(9);
        queue_search(8);
        // Removing the only way out leaves the source with nothing to reach.
        queue_edge(8, 9, NO_EDGE);
        queue_search(8);

        // Random phases: undirected with a slow receiver (and the long
        // hold-off), directed with a slow sender, then undirected flat out.
        for (int phase = 0; phase < 3; phase++) begin
            wait_quiet();
            apb_write(MODE_ADDR, (phase == 1) ? 32'd0 : 32'd1);
            check_mode_reg();
            send_idle_pct <= (phase == 0) ? 28 : (phase == 1) ? 54 : 0;
            recv_idle_pct <= (phase == 0) ? 54 : (phase == 1) ? 28 : 0;
            queue_random_items(RANDOM_PER_PHASE);
            if (phase == 0)
                hold_arm <= 1'b1;
        end

        wait_quiet();
        $display("Run covered %0d edge writes and %0d searches in both edge modes,",
                 edges_taken, searches_taken);
        $display("checking %0d settled-vertex words; %0d searches reached all %0d vertices.",
                 words_checked, full_searches, NV);
        if (mismatches == 0 && settled_due_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d words never seen", mismatches, settled_due_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
